/* rtl/snfh_pkg.sv */
// snfh_pkg: shared types, sizes and the gram enumeration table of the skip n-gram hasher
// used by every module of the block; depends on nothing
`default_nettype none

package snfh_pkg;

   localparam int MAX_GRAM   = 4;
   localparam int MAX_SKIP   = 2;
   localparam int HIST_DEPTH = MAX_GRAM + MAX_SKIP;
   localparam int NUM_GRAMS  = 19;

   localparam int DATA_W     = 64;
   localparam int HALF_W     = DATA_W / 2;
   localparam int TOKENS_W   = 3;
   localparam int SKIPS_W    = 2;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
   localparam int SEEN_W     = $clog2(HIST_DEPTH + 1);
   localparam int GRAM_IDX_W = $clog2(NUM_GRAMS + 1);
   localparam int POS_W      = $clog2(MAX_GRAM);

   localparam logic [DATA_W-1:0]   MULT_RESET     = DATA_W'(27942141);
   localparam logic [TOKENS_W-1:0] GRAM_LIMIT_MAX = TOKENS_W'(MAX_GRAM);
   localparam logic [SKIPS_W-1:0]  SKIP_LIMIT_MAX = SKIPS_W'(MAX_SKIP);

   // input transaction
   typedef struct packed {
      logic [DATA_W-1:0]   feature_index;
      logic                sentence_start;
      logic [TOKENS_W-1:0] gram_limit;
      logic [SKIPS_W-1:0]  skip_limit;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [DATA_W-1:0]   gram_index;
      logic [TOKENS_W-1:0] gram_tokens;
      logic [SKIPS_W-1:0]  gram_skips;
      logic                last_of_run;
   } rsp_type;

   // one gram shape: size, skips and the history taps in hashing order
   typedef struct packed {
      logic [TOKENS_W-1:0]                  tokens;
      logic [SKIPS_W-1:0]                   skips;
      logic [MAX_GRAM-1:0][HIST_IDX_W-1:0] taps;
   } gram_entry_type;

   function automatic gram_entry_type mk_entry(input logic [TOKENS_W-1:0] tokens,
                                               input logic [HIST_IDX_W-1:0] t0,
                                               input logic [HIST_IDX_W-1:0] t1,
                                               input logic [HIST_IDX_W-1:0] t2,
                                               input logic [HIST_IDX_W-1:0] t3);
      gram_entry_type e;
      logic [HIST_IDX_W-1:0] sk;
      sk        = t0 - HIST_IDX_W'(tokens - TOKENS_W'(1));
      e.tokens  = tokens;
      e.skips   = sk[SKIPS_W-1:0];
      e.taps[0] = t0;
      e.taps[1] = t1;
      e.taps[2] = t2;
      e.taps[3] = t3;
      return e;
   endfunction

   // grams ending at the newest token: by gap count, then skip vectors in lexicographic order
   function automatic gram_entry_type gram_entry(input logic [GRAM_IDX_W-1:0] idx);
      gram_entry_type e;
      e = '0;
      case (idx)
         5'd0:    e = mk_entry(3'd2, 3'd1, 3'd0, 3'd0, 3'd0);
         5'd1:    e = mk_entry(3'd2, 3'd2, 3'd0, 3'd0, 3'd0);
         5'd2:    e = mk_entry(3'd2, 3'd3, 3'd0, 3'd0, 3'd0);
         5'd3:    e = mk_entry(3'd3, 3'd2, 3'd1, 3'd0, 3'd0);
         5'd4:    e = mk_entry(3'd3, 3'd3, 3'd2, 3'd0, 3'd0);
         5'd5:    e = mk_entry(3'd3, 3'd4, 3'd3, 3'd0, 3'd0);
         5'd6:    e = mk_entry(3'd3, 3'd3, 3'd1, 3'd0, 3'd0);
         5'd7:    e = mk_entry(3'd3, 3'd4, 3'd2, 3'd0, 3'd0);
         5'd8:    e = mk_entry(3'd3, 3'd4, 3'd1, 3'd0, 3'd0);
         5'd9:    e = mk_entry(3'd4, 3'd3, 3'd2, 3'd1, 3'd0);
         5'd10:   e = mk_entry(3'd4, 3'd4, 3'd3, 3'd2, 3'd0);
         5'd11:   e = mk_entry(3'd4, 3'd5, 3'd4, 3'd3, 3'd0);
         5'd12:   e = mk_entry(3'd4, 3'd4, 3'd3, 3'd1, 3'd0);
         5'd13:   e = mk_entry(3'd4, 3'd5, 3'd4, 3'd2, 3'd0);
         5'd14:   e = mk_entry(3'd4, 3'd5, 3'd4, 3'd1, 3'd0);
         5'd15:   e = mk_entry(3'd4, 3'd4, 3'd2, 3'd1, 3'd0);
         5'd16:   e = mk_entry(3'd4, 3'd5, 3'd3, 3'd2, 3'd0);
         5'd17:   e = mk_entry(3'd4, 3'd5, 3'd3, 3'd1, 3'd0);
         5'd18:   e = mk_entry(3'd4, 3'd5, 3'd2, 3'd1, 3'd0);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

/* rtl/skip_ngram_feature_hasher.sv */
// skip_ngram_feature_hasher: k-skip n-gram hashing over a token stream, one token at a time
// each gram is hashed on the shared 32x32 multiplier (three partial products per 64-bit
// multiply-add); a new token is taken only once the sequencer has walked every gram of the last one
// reset (synchronous, active high) clears the sequencer, token count and output valid
// and loads the hash multiplier with its default; the token history is not cleared
`default_nettype none

module skip_ngram_feature_hasher
   import snfh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [DATA_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MASK,
      ST_SCAN,
      ST_MAC,
      ST_EMIT
   } seq_state_type;

   seq_state_type           state_ff;
   logic [SEEN_W-1:0]       tokens_seen_ff;
   logic [TOKENS_W-1:0]     glimit_ff;
   logic [SKIPS_W-1:0]      slimit_ff;
   logic [NUM_GRAMS-1:0]    mask_ff;
   logic [NUM_GRAMS-1:0]    mask_in;
   logic [NUM_GRAMS-1:0]    mask_clr;
   logic [GRAM_IDX_W-1:0]   entry_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [DATA_W-1:0]       hash_ff;
   logic [DATA_W-1:0]       mult_ff;
   logic                    mac_start_ff;
   logic                    mac_start_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;

   logic                    req_accept;
   logic                    out_free;
   logic                    last_tap;
   gram_entry_type          cur;
   logic [HIST_IDX_W-1:0]   rd_idx;
   logic [DATA_W-1:0]       rd_data;
   logic                    mac_done;
   logic [DATA_W-1:0]       mac_result;
   logic [TOKENS_W-1:0]     glimit_clamped;
   logic [SKIPS_W-1:0]      slimit_clamped;
   logic [SEEN_W-1:0]       seen_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur        = gram_entry(entry_ff);
   assign rd_idx     = cur.taps[pos_ff];
   assign last_tap   = (TOKENS_W'(pos_ff) == cur.tokens - TOKENS_W'(1));

   // start the multiply-add on a gram hit and after every tap but the last
   assign mac_start_in = ((state_ff == ST_SCAN) && mask_ff[entry_ff]) ||
                         ((state_ff == ST_MAC) && mac_done && !last_tap);

   // output valid holds until taken, set when a gram is emitted
   assign rsp_valid_in = ((state_ff == ST_EMIT) && out_free) || (rsp_valid_ff && !rsp_ready);

   // token history and shared multiply-add unit
   snfh_history u_history (
      .clock      (clock),
      .shift_en   (req_accept),
      .shift_data (req_data.feature_index),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data)
   );

   snfh_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .start     (mac_start_ff),
      .acc_in    (hash_ff),
      .mult_in   (mult_ff),
      .addend_in (rd_data),
      .done      (mac_done),
      .result    (mac_result)
   );

   // limits clamped and sentence token count
   always_comb begin
      glimit_clamped = req_data.gram_limit;
      if (req_data.gram_limit > GRAM_LIMIT_MAX) begin
         glimit_clamped = GRAM_LIMIT_MAX;
      end
      slimit_clamped = req_data.skip_limit;
      if (req_data.skip_limit > SKIP_LIMIT_MAX) begin
         slimit_clamped = SKIP_LIMIT_MAX;
      end
      if (req_data.sentence_start) begin
         seen_next = SEEN_W'(1);
      end else if (tokens_seen_ff < SEEN_W'(HIST_DEPTH)) begin
         seen_next = tokens_seen_ff + SEEN_W'(1);
      end else begin
         seen_next = tokens_seen_ff;
      end
   end

   // which table entries this token emits
   always_comb begin
      gram_entry_type e;
      for (int i = 0; i < NUM_GRAMS; i++) begin
         e = gram_entry(GRAM_IDX_W'(i));
         mask_in[i] = (e.tokens <= glimit_ff) && (e.skips <= slimit_ff) &&
                      (SEEN_W'(e.taps[0]) < tokens_seen_ff);
      end
   end

   assign mask_clr = mask_ff & ~(NUM_GRAMS'(1) << entry_ff);

   // hash multiplier register
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MULT_RESET;
      end else if (csr_write_en) begin
         mult_ff <= csr_write_data;
      end
   end

   // sequencer over the gram table, with the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tokens_seen_ff <= '0;
         mac_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mask_ff        <= '0;
      end else begin
         mac_start_ff <= mac_start_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  tokens_seen_ff <= seen_next;
                  glimit_ff      <= glimit_clamped;
                  slimit_ff      <= slimit_clamped;
                  state_ff       <= ST_MASK;
               end
            end
            ST_MASK: begin
               mask_ff  <= mask_in;
               entry_ff <= '0;
               pos_ff   <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (mask_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else if (mask_ff[entry_ff]) begin
                  // first token of the gram seeds the hash
                  hash_ff  <= rd_data;
                  pos_ff   <= POS_W'(1);
                  state_ff <= ST_MAC;
               end else begin
                  entry_ff <= entry_ff + GRAM_IDX_W'(1);
               end
            end
            ST_MAC: begin
               if (mac_done) begin
                  hash_ff <= mac_result;
                  if (last_tap) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     pos_ff <= pos_ff + POS_W'(1);
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff.gram_index  <= hash_ff;
                  rsp_ff.gram_tokens <= cur.tokens;
                  rsp_ff.gram_skips  <= cur.skips;
                  rsp_ff.last_of_run <= (mask_clr == '0);
                  mask_ff            <= mask_clr;
                  entry_ff           <= entry_ff + GRAM_IDX_W'(1);
                  pos_ff             <= '0;
                  state_ff           <= ST_SCAN;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/snfh_history.sv */
// snfh_history: shift line of the most recent tokens with one selectable read tap
// depends on snfh_pkg
`default_nettype none

module snfh_history
   import snfh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire logic [DATA_W-1:0]     shift_data,
   input  wire logic [HIST_IDX_W-1:0] rd_idx,
   output logic      [DATA_W-1:0]     rd_data
);

   logic [DATA_W-1:0] hist_ff [HIST_DEPTH];

   // newest token enters at tap zero, no reset needed
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            hist_ff[k] <= hist_ff[k-1];
         end
         hist_ff[0] <= shift_data;
      end
   end

   // read tap chosen by the sequencer
   always_comb begin
      rd_data = '0;
      if (rd_idx < HIST_IDX_W'(HIST_DEPTH)) begin
         rd_data = hist_ff[rd_idx];
      end
   end

endmodule

`default_nettype wire

/* rtl/snfh_mac.sv */
// snfh_mac: shared 64-bit multiply-add (acc * mult + addend, mod 2^64) on one 32x32 multiplier
// depends on snfh_pkg
`default_nettype none

module snfh_mac
   import snfh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] acc_in,
   input  wire logic [DATA_W-1:0] mult_in,
   input  wire logic [DATA_W-1:0] addend_in,
   output logic                   done,
   output logic      [DATA_W-1:0] result
);

   typedef enum logic [2:0] {
      MAC_IDLE,
      MAC_LL,
      MAC_LH,
      MAC_HL,
      MAC_FIN
   } mac_state_type;

   mac_state_type     state_ff;
   logic              done_ff;
   logic [DATA_W-1:0] hv_ff;
   logic [DATA_W-1:0] mv_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] prod_ff;
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [DATA_W-1:0] prod_in;
   logic [DATA_W-1:0] prod_shifted;

   // operand select for the single multiplier
   always_comb begin
      mul_a = hv_ff[HALF_W-1:0];
      mul_b = mv_ff[HALF_W-1:0];
      case (state_ff)
         MAC_LH:  mul_b = mv_ff[DATA_W-1:HALF_W];
         MAC_HL:  mul_a = hv_ff[DATA_W-1:HALF_W];
         default: begin
            mul_a = hv_ff[HALF_W-1:0];
            mul_b = mv_ff[HALF_W-1:0];
         end
      endcase
   end

   assign prod_in      = DATA_W'(mul_a) * DATA_W'(mul_b);
   assign prod_shifted = {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};

   // low product, then the two cross products shifted up by half a word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == MAC_FIN);
         case (state_ff)
            MAC_IDLE: begin
               if (start) begin
                  hv_ff    <= acc_in;
                  mv_ff    <= mult_in;
                  acc_ff   <= addend_in;
                  state_ff <= MAC_LL;
               end
            end
            MAC_LL: begin
               prod_ff  <= prod_in;
               state_ff <= MAC_LH;
            end
            MAC_LH: begin
               acc_ff   <= acc_ff + prod_ff;
               prod_ff  <= prod_in;
               state_ff <= MAC_HL;
            end
            MAC_HL: begin
               acc_ff   <= acc_ff + prod_shifted;
               prod_ff  <= prod_in;
               state_ff <= MAC_FIN;
            end
            MAC_FIN: begin
               acc_ff   <= acc_ff + prod_shifted;
               state_ff <= MAC_IDLE;
            end
            default: state_ff <= MAC_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench: stand-alone check of skip_ngram_feature_hasher with a gram-hash scoreboard
// depends on snfh_pkg and the block's rtl only; drives directed and random sentences
`default_nettype none

module testbench;
   import snfh_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 100;

   // scoreboard: predicts the grams of every accepted token and checks what comes out
   class gram_hash_tracker;
      logic [DATA_W-1:0] multiplier;
      logic [DATA_W-1:0] history [HIST_DEPTH];
      int                seen;
      rsp_type           pending_grams [$];
      int                errors;

      function new();
         multiplier = MULT_RESET;
         seen       = 0;
         errors     = 0;
      endfunction

      function void flag(input string msg);
         errors++;
         if (errors <= 10)
            $display("scoreboard: %s", msg);
      endfunction

      // shift the token in and queue every gram that ends at it, in walk order
      function void note_token(input req_type t);
         int                glim, slim, gaps, s1, s2, s3, k, j, len, span, first_new;
         int                offs [MAX_GRAM];
         logic [DATA_W-1:0] h;
         rsp_type           g;
         if (t.sentence_start)
            seen = 0;
         for (k = HIST_DEPTH - 1; k > 0; k--)
            history[k] = history[k - 1];
         history[0] = t.feature_index;
         if (seen < HIST_DEPTH)
            seen++;
         glim = (t.gram_limit > GRAM_LIMIT_MAX) ? MAX_GRAM : int'(t.gram_limit);
         slim = (t.skip_limit > SKIP_LIMIT_MAX) ? MAX_SKIP : int'(t.skip_limit);
         first_new = pending_grams.size();
         offs[0] = 0;
         // skip vectors in lexicographic order, first gap outermost
         for (gaps = 1; gaps < glim; gaps++)
            for (s1 = 0; s1 <= slim; s1++)
               for (s2 = 0; s2 <= ((gaps >= 2) ? slim - s1 : 0); s2++)
                  for (s3 = 0; s3 <= ((gaps >= 3) ? slim - s1 - s2 : 0); s3++) begin
                     offs[1] = 1 + s1;
                     offs[2] = offs[1] + 1 + s2;
                     offs[3] = offs[2] + 1 + s3;
                     len     = gaps + 1;
                     span    = offs[gaps];
                     // grams reaching before the sentence start are dropped
                     if (span < HIST_DEPTH && span + 1 <= seen) begin
                        h = history[span];
                        for (j = 1; j < len; j++)
                           h = h * multiplier + history[span - offs[j]];
                        g.gram_index  = h;
                        g.gram_tokens = TOKENS_W'(len);
                        g.gram_skips  = SKIPS_W'(span - gaps);
                        g.last_of_run = 1'b0;
                        pending_grams = {pending_grams, g};
                     end
                  end
         if (pending_grams.size() > first_new)
            pending_grams[$].last_of_run = 1'b1;
      endfunction

      // compare one result transaction with the oldest predicted gram
      function void check_gram(input rsp_type got);
         rsp_type want;
         if (pending_grams.size() == 0) begin
            flag($sformatf("unexpected gram index %h tokens %0d skips %0d last %0d",
                           got.gram_index, got.gram_tokens, got.gram_skips, got.last_of_run));
            return;
         end
         want = pending_grams.pop_front();
         if (got.gram_index !== want.gram_index || got.gram_tokens !== want.gram_tokens ||
             got.gram_skips !== want.gram_skips || got.last_of_run !== want.last_of_run)
            flag($sformatf({"gram mismatch: expected index %h tokens %0d skips %0d last %0d,",
                            " got index %h tokens %0d skips %0d last %0d"},
                           want.gram_index, want.gram_tokens, want.gram_skips,
                           want.last_of_run, got.gram_index, got.gram_tokens,
                           got.gram_skips, got.last_of_run));
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   req_type           req_data       = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [DATA_W-1:0] csr_write_data = '0;

   int                send_idle_pct  = 0;
   int                stall_pct      = 0;
   logic              hold_request   = 1'b0;
   int                hold_left      = 0;
   int                quiet_cycles   = 0;

   gram_hash_tracker  tracker        = new();

   skip_ngram_feature_hasher dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: every accepted transaction goes to the scoreboard; watchdog on silence
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_token(req_data);
         if (rsp_valid && rsp_ready)
            tracker.check_gram(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic req_type make_token(input logic [DATA_W-1:0] feat, input logic start,
                                          input int glim, input int slim);
      req_type t;
      t.feature_index  = feat;
      t.sentence_start = start;
      t.gram_limit     = TOKENS_W'(glim);
      t.skip_limit     = SKIPS_W'(slim);
      return t;
   endfunction

   // offer one token, with random idle cycles first; returns at the falling edge after it
   task automatic send_token(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = t;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // wait until every predicted gram has come out and the block has gone quiet
   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending_grams.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_multiplier(input logic [DATA_W-1:0] value);
      drain();
      csr_write_en   = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en        = 1'b0;
      tracker.multiplier  = value;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      @(negedge clock);
   endtask

   // mostly well-formed sentences; some miss the start mark or change limits midway
   task automatic run_sentences(input int items);
      int      left, len, i, glim, slim;
      req_type t;
      left = items;
      while (left > 0) begin
         len  = $urandom_range(1, 10);
         glim = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2, 4);
         slim = $urandom_range(3);
         for (i = 0; i < len && left > 0; i++) begin
            if ($urandom_range(7) == 0) begin
               glim = $urandom_range(7);
               slim = $urandom_range(3);
            end
            case ($urandom_range(15))
               0:       t.feature_index = '0;
               1:       t.feature_index = '1;
               2:       t.feature_index = {1'b1, {(DATA_W - 1){1'b0}}};
               default: t.feature_index = {$urandom(), $urandom()};
            endcase
            t.sentence_start = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
            t.gram_limit     = TOKENS_W'(glim);
            t.skip_limit     = SKIPS_W'(slim);
            send_token(t);
            left--;
         end
      end
   endtask

   initial begin
      req_type directed [$];
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, oversized limits, no-gram limits, restarts
      directed = {directed, make_token('1, 1'b0, 4, 2)};                 // no start mark
      directed = {directed, make_token('0, 1'b0, 4, 2)};
      directed = {directed, make_token({1'b1, {(DATA_W - 1){1'b0}}}, 1'b0, 4, 2)};
      directed = {directed, make_token(64'd1, 1'b0, 7, 3)};              // oversized limits
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 4, 2)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 5, 2)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 4, 2)};  // full window
      directed = {directed, make_token('1, 1'b0, 6, 3)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 0, 2)};  // no grams
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 1, 1)};  // no grams
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 2, 0)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 3, 1)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 3, 0)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 2, 2)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b1, 4, 2)};  // restart
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 4, 2)};
      directed = {directed, make_token('0, 1'b1, 3, 1)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 3, 1)};
      directed = {directed, make_token('1, 1'b0, 3, 1)};
      directed = {directed, make_token({$urandom(), $urandom()}, 1'b0, 4, 0)};
      foreach (directed[n])
         send_token(directed[n]);

      // random phases, each under its own multiplier and with a chosen idling mix
      write_multiplier('0);
      set_idling(0, 0);
      run_sentences(64);

      write_multiplier('1);
      set_idling(73, 0);
      run_sentences(64);

      write_multiplier({$urandom(), $urandom()});
      set_idling(0, 73);
      run_sentences(64);

      write_multiplier({1'b1, {(DATA_W - 2){1'b0}}, 1'b1});
      set_idling(35, 35);
      run_sentences(64);

      // long receiver hold-off while tokens keep coming
      write_multiplier(MULT_RESET);
      set_idling(0, 0);
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      run_sentences(64);

      drain();
      if (tracker.pending_grams.size() != 0)
         tracker.flag($sformatf("%0d grams never arrived", tracker.pending_grams.size()));
      if (tracker.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire

/* skip_ngram_feature_hasher.f */
rtl/snfh_pkg.sv
rtl/snfh_history.sv
rtl/snfh_mac.sv
rtl/skip_ngram_feature_hasher.sv
dv/testbench.sv
